// ----- design/tdh_pkg.sv -----
`default_nettype none

package tdh_pkg;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_DIVIDER  = 3'd1;
    localparam logic [2:0] REG_DELTA    = 3'd2;
    localparam logic [2:0] REG_NEEDED   = 3'd3;
    localparam logic [2:0] REG_ENTER    = 3'd4;
    localparam logic [2:0] REG_LEAVE    = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEBOUNCE,
        ST_MAC,
        ST_JUDGE,
        ST_DONE
    } state_t;

    // Multiply-accumulate step control
    typedef struct packed {
        logic en;
        logic clr;
        logic shift16;
    } mac_ctl_t;

    localparam int OPND_W = 17;
    localparam int ACC_W  = 48;

endpackage

`default_nettype wire

// ----- design/tdh_mac.sv -----
`default_nettype none

// Shared multiply-accumulate unit: acc <= (clr ? 0 : acc) + (a*b << (shift16 ? 16 : 0)).
// Operands are signed; every product used here is nonnegative.
module tdh_mac (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire tdh_pkg::mac_ctl_t               ctl,
    input  wire signed [tdh_pkg::OPND_W-1:0]     a,
    input  wire signed [tdh_pkg::OPND_W-1:0]     b,
    output logic       [tdh_pkg::ACC_W-1:0]      acc
);

    logic signed [2*tdh_pkg::OPND_W-1:0] prod;
    logic        [tdh_pkg::ACC_W-1:0]    term;
    logic        [tdh_pkg::ACC_W-1:0]    acc_reg;
    logic        [tdh_pkg::ACC_W-1:0]    acc_next;

    // Product and alignment
    always_comb
    begin
        prod = a * b;
        if (ctl.shift16)
        begin
            term = {prod[31:0], 16'h0000};
        end
        else
        begin
            term = {14'h0000, prod[33:0]};
        end
        acc_next = (ctl.clr ? '0 : acc_reg) + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- design/tilt_detector_debounced_hysteresis.sv -----
`default_nettype none

// Debounced tilt detector with hysteresis. Each accepted input word is one timer tick with a
// three-axis sample and yields exactly one output word (action, tilted, sampled). Ticks that
// are not evaluated (disabled, or between divider hits) go straight to delivery; an evaluated
// tick ends after the debounce check when the sample is unstable or the stable run is too
// short, and goes on to the tilt test otherwise. The debounce check runs one axis a cycle; the
// single shared 17x17 multiply-accumulate unit forms x^2+y^2+z^2 and the 48-bit threshold
// product over five passes. A finished word waits in the output register while the next tick
// is accepted; the next result only moves into that register once it is free.
module tilt_detector_debounced_hysteresis (
    input  wire                 clk,
    input  wire                 rst_n,
    // configuration
    input  wire                 cfg_we,
    input  wire  [2:0]          cfg_index,
    input  wire  [15:0]         cfg_data,
    // input channel
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire  signed [15:0]  accel_x,
    input  wire  signed [15:0]  accel_y,
    input  wire  signed [15:0]  accel_z,
    // output channel
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [1:0]          action,
    output logic                tilted,
    output logic                sampled
);

    // Configuration registers
    logic        enable_reg;
    logic [7:0]  divider_reg;
    logic [15:0] delta_reg;
    logic [7:0]  needed_reg;
    logic [15:0] enter_reg;
    logic [15:0] leave_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            divider_reg <= 8'd10;
            delta_reg   <= 16'd200;
            needed_reg  <= 8'd3;
            enter_reg   <= 16'd32768;
            leave_reg   <= 16'd24576;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tdh_pkg::REG_ENABLE:  enable_reg  <= cfg_data[0];
                tdh_pkg::REG_DIVIDER: divider_reg <= cfg_data[7:0];
                tdh_pkg::REG_DELTA:   delta_reg   <= cfg_data;
                tdh_pkg::REG_NEEDED:  needed_reg  <= cfg_data[7:0];
                tdh_pkg::REG_ENTER:   enter_reg   <= cfg_data;
                tdh_pkg::REG_LEAVE:   leave_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath state
    tdh_pkg::state_t         state_reg, state_next;
    logic [7:0]              phase_reg, phase_next;
    logic [7:0]              run_reg, run_next;
    logic                    tilt_reg, tilt_next;
    logic [1:0]              step_reg, step_next;
    logic [2:0]              mstep_reg, mstep_next;
    logic                    stable_reg, stable_next;
    logic signed [15:0]      sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic signed [15:0]      px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [31:0]             horiz_reg, horiz_next;
    logic [31:0]             mag_reg, mag_next;
    tdh_pkg::action_t        ract_reg, ract_next;
    logic                    rtilt_reg, rtilt_next;
    logic                    rsamp_reg, rsamp_next;
    logic                    ovalid_reg, ovalid_next;
    tdh_pkg::action_t        oact_reg, oact_next;
    logic                    otilt_reg, otilt_next;
    logic                    osamp_reg, osamp_next;

    // Shared unit hookup
    tdh_pkg::mac_ctl_t                   mac_ctl;
    logic signed [tdh_pkg::OPND_W-1:0]   mac_a, mac_b;
    logic        [tdh_pkg::ACC_W-1:0]    mac_acc;

    tdh_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    // Scratch values
    logic [7:0]          div_eff;
    logic [7:0]          phase_inc;
    logic                hit;
    logic signed [15:0]  cur_s, cur_p;
    logic signed [16:0]  diff;
    logic [16:0]         absd;
    logic                axis_ok;
    logic                all_ok;
    logic [7:0]          run_inc;
    logic [15:0]         thr;
    logic                now_tilt;
    logic                out_free;

    always_comb
    begin
        // defaults
        state_next  = state_reg;
        phase_next  = phase_reg;
        run_next    = run_reg;
        tilt_next   = tilt_reg;
        step_next   = step_reg;
        mstep_next  = mstep_reg;
        stable_next = stable_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sz_next     = sz_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pz_next     = pz_reg;
        horiz_next  = horiz_reg;
        mag_next    = mag_reg;
        ract_next   = ract_reg;
        rtilt_next  = rtilt_reg;
        rsamp_next  = rsamp_reg;
        ovalid_next = ovalid_reg;
        oact_next   = oact_reg;
        otilt_next  = otilt_reg;
        osamp_next  = osamp_reg;
        in_stall    = 1'b1;
        mac_ctl     = '0;
        mac_a       = '0;
        mac_b       = '0;

        // output register drains
        out_free = !ovalid_reg || !out_stall;
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        // tick phase; a zero divider acts as one
        div_eff   = (divider_reg == 8'd0) ? 8'd1 : divider_reg;
        phase_inc = phase_reg + 8'd1;
        hit       = (phase_inc >= div_eff);

        // per-axis debounce check
        case (step_reg)
            2'd0:    begin cur_s = sx_reg; cur_p = px_reg; end
            2'd1:    begin cur_s = sy_reg; cur_p = py_reg; end
            default: begin cur_s = sz_reg; cur_p = pz_reg; end
        endcase
        diff    = {cur_s[15], cur_s} - {cur_p[15], cur_p};
        absd    = diff[16] ? 17'(-diff) : 17'(diff);
        axis_ok = (absd < {1'b0, delta_reg});
        all_ok  = stable_reg && axis_ok;
        run_inc = (run_reg == 8'd255) ? run_reg : run_reg + 8'd1;

        // tilt test
        thr      = tilt_reg ? leave_reg : enter_reg;
        now_tilt = ({horiz_reg, 16'h0000} > mac_acc);

        case (state_reg)
            tdh_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    phase_next = hit ? 8'd0 : phase_inc;
                    sx_next    = accel_x;
                    sy_next    = accel_y;
                    sz_next    = accel_z;
                    ract_next  = tdh_pkg::ACT_NONE;
                    rtilt_next = tilt_reg;
                    rsamp_next = 1'b0;
                    if (!enable_reg)
                    begin
                        rtilt_next = 1'b0;
                        if (tilt_reg)
                        begin
                            ract_next = tdh_pkg::ACT_STOP;
                        end
                        state_next = tdh_pkg::ST_DONE;
                    end
                    else if (hit)
                    begin
                        rsamp_next  = 1'b1;
                        step_next   = 2'd0;
                        stable_next = 1'b1;
                        state_next  = tdh_pkg::ST_DEBOUNCE;
                    end
                    else
                    begin
                        state_next = tdh_pkg::ST_DONE;
                    end
                end
            end

            tdh_pkg::ST_DEBOUNCE:
            begin
                stable_next = all_ok;
                if (step_reg == 2'd2)
                begin
                    px_next = sx_reg;
                    py_next = sy_reg;
                    pz_next = sz_reg;
                    if (!all_ok)
                    begin
                        run_next   = 8'd0;
                        state_next = tdh_pkg::ST_DONE;
                    end
                    else
                    begin
                        run_next = run_inc;
                        if (run_inc >= needed_reg)
                        begin
                            mstep_next = 3'd0;
                            state_next = tdh_pkg::ST_MAC;
                        end
                        else
                        begin
                            state_next = tdh_pkg::ST_DONE;
                        end
                    end
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end

            // x^2, +y^2, +z^2, then thr*mag in two 16-bit halves
            tdh_pkg::ST_MAC:
            begin
                mac_ctl.en = 1'b1;
                mstep_next = mstep_reg + 3'd1;
                case (mstep_reg)
                    3'd0:
                    begin
                        mac_ctl.clr = 1'b1;
                        mac_a = {sx_reg[15], sx_reg};
                        mac_b = {sx_reg[15], sx_reg};
                    end
                    3'd1:
                    begin
                        mac_a = {sy_reg[15], sy_reg};
                        mac_b = {sy_reg[15], sy_reg};
                    end
                    3'd2:
                    begin
                        horiz_next = mac_acc[31:0];
                        mac_a = {sz_reg[15], sz_reg};
                        mac_b = {sz_reg[15], sz_reg};
                    end
                    3'd3:
                    begin
                        mag_next    = mac_acc[31:0];
                        mac_ctl.clr = 1'b1;
                        mac_a = {1'b0, thr};
                        mac_b = {1'b0, mac_acc[15:0]};
                    end
                    default:
                    begin
                        mac_ctl.shift16 = 1'b1;
                        mac_a = {1'b0, thr};
                        mac_b = {1'b0, mag_reg[31:16]};
                        state_next = tdh_pkg::ST_JUDGE;
                    end
                endcase
            end

            // hysteresis decision; an all-zero sample leaves the state alone
            tdh_pkg::ST_JUDGE:
            begin
                if (mag_reg != 32'd0)
                begin
                    rtilt_next = now_tilt;
                    if (now_tilt && !tilt_reg)
                    begin
                        ract_next = tdh_pkg::ACT_START;
                    end
                    else if (!now_tilt && tilt_reg)
                    begin
                        ract_next = tdh_pkg::ACT_STOP;
                    end
                end
                state_next = tdh_pkg::ST_DONE;
            end

            tdh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oact_next   = ract_reg;
                    otilt_next  = rtilt_reg;
                    osamp_next  = rsamp_reg;
                    tilt_next   = rtilt_reg;
                    state_next  = tdh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tdh_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tdh_pkg::ST_IDLE;
            phase_reg  <= 8'd0;
            run_reg    <= 8'd0;
            tilt_reg   <= 1'b0;
            step_reg   <= 2'd0;
            mstep_reg  <= 3'd0;
            px_reg     <= 16'sd0;
            py_reg     <= 16'sd0;
            pz_reg     <= 16'sd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            tilt_reg   <= tilt_next;
            step_reg   <= step_next;
            mstep_reg  <= mstep_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        stable_reg <= stable_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        sz_reg     <= sz_next;
        horiz_reg  <= horiz_next;
        mag_reg    <= mag_next;
        ract_reg   <= ract_next;
        rtilt_reg  <= rtilt_next;
        rsamp_reg  <= rsamp_next;
        oact_reg   <= oact_next;
        otilt_reg  <= otilt_next;
        osamp_reg  <= osamp_next;
    end

    assign out_valid = ovalid_reg;
    assign action    = oact_reg;
    assign tilted    = otilt_reg;
    assign sampled   = osamp_reg;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } tick_t;

    typedef struct packed {
        tdh_pkg::action_t act;
        logic             tilted;
        logic             sampled;
    } tick_result_t;

    // DUT ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = tdh_pkg::REG_ENABLE;
    logic [15:0]        cfg_data = 16'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] accel_x = 16'sd0;
    logic signed [15:0] accel_y = 16'sd0;
    logic signed [15:0] accel_z = 16'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         action;
    logic               tilted;
    logic               sampled;

    // register copies, at their reset values
    logic        sh_enable  = 1'b1;
    logic [7:0]  sh_divider = 8'd10;
    logic [15:0] sh_delta   = 16'd200;
    logic [7:0]  sh_needed  = 8'd3;
    logic [15:0] sh_enter   = 16'd32768;
    logic [15:0] sh_leave   = 16'd24576;

    // detector state as predicted
    logic [7:0]         tick_phase = 8'd0;
    logic signed [15:0] prev_x = 16'sd0;
    logic signed [15:0] prev_y = 16'sd0;
    logic signed [15:0] prev_z = 16'sd0;
    logic [7:0]         stable_run = 8'd0;
    logic               tilt_state = 1'b0;

    // queues and bookkeeping
    tick_t        tick_queue[$];
    tick_result_t due_results[$];
    int           ticks_sent = 0;
    int           ticks_taken = 0;
    int           mismatch_count = 0;
    int           tx_idle_pct = 9;
    int           rx_idle_pct = 64;
    bit           word_taken = 1'b0;

    // random-walk position for generated samples
    int walk_x = 0;
    int walk_y = 0;
    int walk_z = 16384;

    tilt_detector_debounced_hysteresis dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .action    (action),
        .tilted    (tilted),
        .sampled   (sampled)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int abs_diff(input logic signed [15:0] a, input logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    // one tick through the detector: divider, debounce, hysteresis tilt test
    function automatic tick_result_t predict_tick(input logic signed [15:0] x,
                                                  input logic signed [15:0] y,
                                                  input logic signed [15:0] z);
        tick_result_t r;
        logic [7:0]   div;
        logic         hit;
        logic         steady;
        longint       horiz;
        longint       mag;
        longint       thr;
        r.act = tdh_pkg::ACT_NONE;
        r.sampled = 1'b0;
        div = (sh_divider == 8'd0) ? 8'd1 : sh_divider;
        tick_phase = tick_phase + 8'd1;
        hit = (tick_phase >= div);
        if (hit)
            tick_phase = 8'd0;
        if (!sh_enable)
        begin
            if (tilt_state)
            begin
                tilt_state = 1'b0;
                r.act = tdh_pkg::ACT_STOP;
            end
        end
        else if (hit)
        begin
            steady = abs_diff(x, prev_x) < int'(sh_delta) &&
                     abs_diff(y, prev_y) < int'(sh_delta) &&
                     abs_diff(z, prev_z) < int'(sh_delta);
            r.sampled = 1'b1;
            prev_x = x;
            prev_y = y;
            prev_z = z;
            if (!steady)
                stable_run = 8'd0;
            else
            begin
                if (stable_run != 8'd255)
                    stable_run = stable_run + 8'd1;
                if (stable_run >= sh_needed)
                begin
                    horiz = longint'(x) * longint'(x) + longint'(y) * longint'(y);
                    mag = horiz + longint'(z) * longint'(z);
                    // all-zero sample keeps the current state
                    if (mag != 0)
                    begin
                        thr = tilt_state ? longint'(sh_leave) : longint'(sh_enter);
                        if (horiz * 65536 > thr * mag)
                        begin
                            if (!tilt_state)
                                r.act = tdh_pkg::ACT_START;
                            tilt_state = 1'b1;
                        end
                        else
                        begin
                            if (tilt_state)
                                r.act = tdh_pkg::ACT_STOP;
                            tilt_state = 1'b0;
                        end
                    end
                end
            end
        end
        r.tilted = tilt_state;
        return r;
    endfunction

    // input words: present the next pending tick, hold it until taken
    always @(negedge clk)
    begin : drive_in
        tick_t t;
        if (rst_n)
        begin
            if (!in_valid || word_taken)
            begin
                word_taken = 1'b0;
                if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    t = tick_queue.pop_front();
                    in_valid <= 1'b1;
                    accel_x  <= t.x;
                    accel_y  <= t.y;
                    accel_z  <= t.z;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // watch both channels: predict on accept, check each delivered word
    always @(posedge clk)
    begin : watch
        tick_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                due_results.push_back(predict_tick(accel_x, accel_y, accel_z));
                ticks_taken++;
                word_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    note_mismatch("unexpected word", int'(action), -1);
                else
                begin
                    want = due_results.pop_front();
                    if (action !== want.act)
                        note_mismatch("action", int'(action), int'(want.act));
                    if (tilted !== want.tilted)
                        note_mismatch("tilted", int'(tilted), int'(want.tilted));
                    if (sampled !== want.sampled)
                        note_mismatch("sampled", int'(sampled), int'(want.sampled));
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tdh_pkg::REG_ENABLE:  sh_enable  = val[0];
            tdh_pkg::REG_DIVIDER: sh_divider = val[7:0];
            tdh_pkg::REG_DELTA:   sh_delta   = val;
            tdh_pkg::REG_NEEDED:  sh_needed  = val[7:0];
            tdh_pkg::REG_ENTER:   sh_enter   = val;
            tdh_pkg::REG_LEAVE:   sh_leave   = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [7:0] div, input logic [15:0] delta,
                              input logic [7:0] need, input logic [15:0] enter,
                              input logic [15:0] leave);
        write_reg(tdh_pkg::REG_ENABLE, {15'd0, en});
        write_reg(tdh_pkg::REG_DIVIDER, {8'd0, div});
        write_reg(tdh_pkg::REG_DELTA, delta);
        write_reg(tdh_pkg::REG_NEEDED, {8'd0, need});
        write_reg(tdh_pkg::REG_ENTER, enter);
        write_reg(tdh_pkg::REG_LEAVE, leave);
    endtask

    task automatic push_tick(input int x, input int y, input int z);
        tick_t t;
        t.x = x[15:0];
        t.y = y[15:0];
        t.z = z[15:0];
        tick_queue.push_back(t);
        ticks_sent++;
    endtask

    // next sample: mostly small jitter inside the stable window, sometimes a jump
    task automatic walk_step();
        int r;
        int j;
        int ax;
        int extremes[3] = '{-32768, 0, 32767};
        r = $urandom_range(99);
        j = (int'(sh_delta) > 1) ? (int'(sh_delta) - 1) / 2 : 0;
        if (r < 8)
        begin
            case ($urandom_range(4))
                0:
                begin
                    walk_x = int'($urandom_range(65535)) - 32768;
                    walk_y = int'($urandom_range(65535)) - 32768;
                    walk_z = int'($urandom_range(65535)) - 32768;
                end
                1:
                begin
                    // lying flat
                    walk_x = int'($urandom_range(65535)) - 32768;
                    walk_y = int'($urandom_range(65535)) - 32768;
                    walk_z = 0;
                end
                2:
                begin
                    // upright
                    walk_x = 0;
                    walk_y = 0;
                    walk_z = int'($urandom_range(65535)) - 32768;
                end
                3:
                begin
                    walk_x = extremes[$urandom_range(2)];
                    walk_y = extremes[$urandom_range(2)];
                    walk_z = extremes[$urandom_range(2)];
                end
                default:
                begin
                    walk_x = 0;
                    walk_y = 0;
                    walk_z = 0;
                end
            endcase
        end
        else if (r < 13)
        begin
            // one axis moves by exactly the limit or one less
            ax = $urandom_range(2);
            j = int'(sh_delta) - int'($urandom_range(1));
            if ($urandom_range(1))
                j = -j;
            case (ax)
                0: walk_x += j;
                1: walk_y += j;
                default: walk_z += j;
            endcase
        end
        else
        begin
            walk_x += int'($urandom_range(2 * j)) - j;
            walk_y += int'($urandom_range(2 * j)) - j;
            walk_z += int'($urandom_range(2 * j)) - j;
        end
        walk_x = clamp16(walk_x);
        walk_y = clamp16(walk_y);
        walk_z = clamp16(walk_z);
        push_tick(walk_x, walk_y, walk_z);
    endtask

    // wait until every tick is taken and answered, then let the block settle
    task automatic drain();
        while (ticks_taken != ticks_sent || due_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int p;
        int n;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset values: only the tenth tick is evaluated, a small change is stable
        repeat (10) push_tick(0, 0, 100);
        drain();

        // every tick evaluated, only a full-scale swing is unstable
        set_config(1'b1, 8'd1, 16'hFFFF, 8'd1, 16'd32768, 16'd24576);
        push_tick(0, 0, 0);                 // zero sample, stays untilted
        push_tick(32767, 0, 0);             // enters tilt
        push_tick(-32768, -32768, -32768);  // difference of 65535 breaks the run
        push_tick(-32768, -32768, -32768);  // held by the leave threshold
        push_tick(0, 0, 0);                 // zero sample while tilted
        push_tick(0, 0, 32767);             // upright, leaves tilt
        push_tick(23170, 0, 23170);         // 45 degrees lands exactly on the threshold
        push_tick(32767, 32767, 32767);
        push_tick(0, 0, -32768);
        push_tick(32767, -32768, 0);
        drain();

        // disabling clears tilt on the next tick only
        write_reg(tdh_pkg::REG_ENABLE, 16'd0);
        push_tick(1, 2, 3);
        push_tick(-1, -2, -3);
        drain();

        // lower the divider below the running phase
        write_reg(tdh_pkg::REG_ENABLE, 16'd1);
        write_reg(tdh_pkg::REG_DIVIDER, 16'd20);
        repeat (6) push_tick(32767, -32768, 0);
        drain();
        write_reg(tdh_pkg::REG_DIVIDER, 16'd3);
        push_tick(32767, -32768, 0);
        drain();

        // random phases; idling moves from the receiver to the sender, then stops
        for (p = 0; p < 12; p++)
        begin
            tx_idle_pct = (p < 4) ? 9 : (p < 8) ? 64 : 0;
            rx_idle_pct = (p < 4) ? 64 : (p < 8) ? 9 : 0;
            n = 40;
            case (p)
                0: set_config(1'b1, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0);
                1: set_config(1'b0, 8'($urandom_range(1, 3)), 16'($urandom_range(1, 65535)),
                              8'($urandom_range(1, 5)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)));
                5:
                begin
                    // long stable run saturates the counter
                    set_config(1'b1, 8'd1, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF);
                    n = 300;
                end
                9:
                begin
                    set_config(1'b1, 8'd255, 16'hFFFF, 8'd1, 16'($urandom_range(65535)),
                               16'($urandom_range(65535)));
                    n = 260;
                end
                default:
                    set_config($urandom_range(9) != 0,
                               ($urandom_range(9) == 0) ? 8'($urandom_range(5, 255))
                                                        : 8'($urandom_range(1, 4)),
                               ($urandom_range(9) < 7) ? 16'($urandom_range(50, 5000))
                                                       : 16'($urandom_range(1, 65535)),
                               8'($urandom_range(1, 5)),
                               16'($urandom_range(65535)), 16'($urandom_range(65535)));
            endcase
            repeat (n) walk_step();
            drain();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/tdh_pkg.sv
design/tdh_mac.sv
design/tilt_detector_debounced_hysteresis.sv
tb/tb_top.sv
